// ----- rtl/rsas_pkg.sv -----
// Package for the rotated sorted array search block.
// Holds widths, codes, state types and the controller/datapath command and status bundles.
// No dependencies.
package rsas_pkg;

    localparam int DEPTH_DEF = 1024;
    localparam int DATA_W    = 32;
    localparam int POS_W     = 10;

    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOW,
        ST_MID,
        ST_HIGH,
        ST_CMP
    } t_state;

    typedef enum logic [1:0] {
        RD_LOW,
        RD_MID,
        RD_HIGH
    } t_rd_sel;

    typedef struct packed {
        logic    load;
        logic    init;
        logic    rd_en;
        t_rd_sel rd_sel;
        logic    cap_low;
        logic    cap_mid;
        logic    step;
        logic    miss;
    } t_cmd;

    typedef struct packed {
        logic live;
        logic hit;
    } t_status;

endpackage

// ----- rtl/rsas_ctrl.sv -----
// Controller for the rotated sorted array search block.
// Sequences the three element reads and the compare of each halving step.
// Depends on rsas_pkg.
module rsas_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic             i_mode,
    input  rsas_pkg::t_status i_status,
    output rsas_pkg::t_cmd   o_cmd,
    output logic             o_busy
);
    import rsas_pkg::*;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start && i_mode == MODE_SEARCH) begin
                    n_state = ST_LOW;
                end
            end
            ST_LOW: begin
                n_state = i_status.live ? ST_MID : ST_IDLE;
            end
            ST_MID:  n_state = ST_HIGH;
            ST_HIGH: n_state = ST_CMP;
            ST_CMP: begin
                n_state = i_status.hit ? ST_IDLE : ST_LOW;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_start && i_mode == MODE_LOAD;
                o_cmd.init = i_start && i_mode == MODE_SEARCH;
            end
            ST_LOW: begin
                o_cmd.rd_en  = i_status.live;
                o_cmd.rd_sel = RD_LOW;
                o_cmd.miss   = !i_status.live;
            end
            ST_MID: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_MID;
                o_cmd.cap_low = 1'b1;
            end
            ST_HIGH: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_sel  = RD_HIGH;
                o_cmd.cap_mid = 1'b1;
            end
            ST_CMP: begin
                o_cmd.step = 1'b1;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

// ----- rtl/rsas_dpath.sv -----
// Datapath for the rotated sorted array search block.
// Holds the element store, element count, search bounds and result register.
// Depends on rsas_pkg.
module rsas_dpath #(
    parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  rsas_pkg::t_cmd              i_cmd,
    input  logic signed [rsas_pkg::DATA_W-1:0] i_value,
    input  logic                        i_first,
    output rsas_pkg::t_status           o_status,
    output logic                        o_valid,
    output logic                        o_found,
    output logic [rsas_pkg::POS_W-1:0]  o_position
);
    import rsas_pkg::*;

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic signed [DATA_W-1:0] mem [DEPTH];

    logic [CW-1:0]            r_count;
    logic [CW-1:0]            r_low;
    logic [CW-1:0]            r_hp1;
    logic signed [DATA_W-1:0] r_target;
    logic signed [DATA_W-1:0] r_a_low;
    logic signed [DATA_W-1:0] r_a_mid;
    logic signed [DATA_W-1:0] r_rdata;
    logic                     r_valid;
    logic                     r_found;
    logic [POS_W-1:0]         r_pos;

    logic [CW-1:0]            mid;
    logic [CW-1:0]            high;
    logic [IW-1:0]            rd_addr;
    logic [IW-1:0]            wr_addr;
    logic                     wr_en;
    logic                     hit;
    logic                     go_up;

    assign high = r_hp1 - CW'(1);
    assign mid  = r_low + ((r_hp1 - r_low - CW'(1)) >> 1);
    assign hit  = r_a_mid == r_target;

    assign o_status.live = r_low < r_hp1;
    assign o_status.hit  = hit;

    always_comb begin
        case (i_cmd.rd_sel)
            RD_LOW:  rd_addr = r_low[IW-1:0];
            RD_MID:  rd_addr = mid[IW-1:0];
            default: rd_addr = high[IW-1:0];
        endcase
    end

    assign wr_en   = i_cmd.load && (i_first || r_count < CW'(DEPTH));
    assign wr_addr = i_first ? '0 : r_count[IW-1:0];

    always_comb begin
        if (r_a_low <= r_a_mid) begin
            go_up = !(r_a_low <= r_target && r_target < r_a_mid);
        end else begin
            go_up = r_a_mid < r_target && r_target <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= i_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (wr_en) begin
            r_count <= i_first ? CW'(1) : r_count + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_target <= i_value;
            r_low    <= '0;
            r_hp1    <= r_count;
        end else if (i_cmd.step && !hit) begin
            if (go_up) begin
                r_low <= mid + CW'(1);
            end else begin
                r_hp1 <= mid;
            end
        end
        if (i_cmd.cap_low) begin
            r_a_low <= r_rdata;
        end
        if (i_cmd.cap_mid) begin
            r_a_mid <= r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_found <= 1'b0;
            r_pos   <= '0;
        end else begin
            r_valid <= i_cmd.miss || (i_cmd.step && hit);
            if (i_cmd.miss) begin
                r_found <= 1'b0;
                r_pos   <= '0;
            end else if (i_cmd.step && hit) begin
                r_found <= 1'b1;
                r_pos   <= POS_W'(mid);
            end
        end
    end

    assign o_valid    = r_valid;
    assign o_found    = r_found;
    assign o_position = r_pos;

endmodule

// ----- rtl/rotated_sorted_array_search.sv -----
// Top level of the rotated sorted array search block.
// Joins the controller and the datapath; depends on rsas_pkg, rsas_ctrl, rsas_dpath.
//
//   channel   | handshake          | payload
//   ----------+--------------------+-----------------------------
//   request   | start / busy       | i_mode, i_value, i_first
//   result    | o_valid (strobe)   | o_found, o_position
//
// A load request never raises busy.
// A search request reads the low, mid and high entries one after another
// through the single store read port, then compares, for each halving step;
// it ends on a hit or when the search bounds are empty.
// Reset clears the element count, controller state and result register; the store is not cleared.
// The result strobe lasts one cycle; the receiver cannot stall it.
module rotated_sorted_array_search #(
    parameter int DEPTH = rsas_pkg::DEPTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              i_mode,
    input  logic signed [rsas_pkg::DATA_W-1:0] i_value,
    input  logic                              i_first,
    output logic                              o_valid,
    output logic                              o_found,
    output logic [rsas_pkg::POS_W-1:0]        o_position
);
    import rsas_pkg::*;

    t_cmd    cmd;
    t_status status;

    rsas_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_mode   (i_mode),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy)
    );

    rsas_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_value    (i_value),
        .i_first    (i_first),
        .o_status   (status),
        .o_valid    (o_valid),
        .o_found    (o_found),
        .o_position (o_position)
    );

endmodule

// ----- rtl/rsas_checker.sv -----
// Port-level checks for the rotated sorted array search block.
// Bound to rotated_sorted_array_search; depends on rsas_pkg.
module rsas_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        i_mode,
    input logic                        o_valid,
    input logic                        o_found,
    input logic [rsas_pkg::POS_W-1:0]  o_position
);
    import rsas_pkg::*;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe held for more than one cycle");

    a_miss_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_found |-> o_position == '0)
        else $error("not-found result with non-zero position");

    a_idle_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !busy)
        else $error("busy while result shown");

    a_load_no_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode == MODE_LOAD |=> !busy)
        else $error("load request raised busy");

    a_search_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start && !busy && i_mode == MODE_SEARCH |=> busy && !o_valid)
        else $error("search request did not raise busy");

endmodule

bind rotated_sorted_array_search rsas_checker u_rsas_checker (.*);
